// ===== design/dmap_pkg.sv =====
// ----------------------------------------------------------------------------
// Diameter message parser package
// Result codes, result record type and the constants shared by the parser
// top level, its output queue and its port checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmap_pkg;

   // result kinds
   localparam logic [2:0] KIND_HEADER     = 3'd0;
   localparam logic [2:0] KIND_AVP_HEADER = 3'd1;
   localparam logic [2:0] KIND_AVP_DATA   = 3'd2;
   localparam logic [2:0] KIND_MSG_END    = 3'd3;
   localparam logic [2:0] KIND_ERROR      = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_VERSION       = 3'd1;
   localparam logic [2:0] ERR_MSG_LONG      = 3'd2;
   localparam logic [2:0] ERR_AVP_HDR_SHORT = 3'd3;
   localparam logic [2:0] ERR_AVP_LENGTH    = 3'd4;
   localparam logic [2:0] ERR_DATA_SHORT    = 3'd5;
   localparam logic [2:0] ERR_BUF_UNDER_HDR = 3'd6;

   // protocol constants
   localparam logic [7:0]  VERSION_OK       = 8'd1;
   localparam int unsigned VENDOR_FLAG_BIT  = 7;
   localparam logic [23:0] LAST_HDR_POS     = 24'd19;
   localparam logic [23:0] HDR_MSG_LEN      = 24'd20;
   localparam logic [23:0] AVP_HDR_PLAIN    = 24'd8;
   localparam logic [23:0] AVP_HDR_VENDOR   = 24'd12;

   // output queue sizing
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  err_code;
      logic [7:0]  flags_out;
      logic [31:0] code_out;
      logic [31:0] ident_out;
      logic [31:0] hop_out;
      logic [31:0] end_out;
      logic [23:0] length_out;
      logic [7:0]  data_out;
      logic        last_of_run;
   } rsp_payload_type;

   function automatic rsp_payload_type make_rsp(
      input logic [2:0]  kind,
      input logic [2:0]  err_code,
      input logic [7:0]  flags,
      input logic [31:0] code,
      input logic [31:0] ident,
      input logic [31:0] hop,
      input logic [31:0] e2e,
      input logic [23:0] len,
      input logic [7:0]  data
   );
      rsp_payload_type r;
      r.kind        = kind;
      r.err_code    = err_code;
      r.flags_out   = flags;
      r.code_out    = code;
      r.ident_out   = ident;
      r.hop_out     = hop;
      r.end_out     = e2e;
      r.length_out  = len;
      r.data_out    = data;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

// ===== design/dmap_req_if.sv =====
// ----------------------------------------------------------------------------
// Diameter parser byte channel
// Valid/ready channel carrying one message byte and the buffer end flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

// ===== design/dmap_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Diameter parser result channel
// Valid/ready channel carrying one parse result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmap_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [2:0]  err_code;
   logic [7:0]  flags_out;
   logic [31:0] code_out;
   logic [31:0] ident_out;
   logic [31:0] hop_out;
   logic [31:0] end_out;
   logic [23:0] length_out;
   logic [7:0]  data_out;
   logic        last_of_run;

   modport source (
      output valid, output kind, output err_code, output flags_out, output code_out,
      output ident_out, output hop_out, output end_out, output length_out,
      output data_out, output last_of_run, input ready
   );
   modport sink (
      input valid, input kind, input err_code, input flags_out, input code_out,
      input ident_out, input hop_out, input end_out, input length_out,
      input data_out, input last_of_run, output ready
   );
endinterface

// ===== design/diameter_message_avp_parser.sv =====
// ----------------------------------------------------------------------------
// Diameter message and AVP parser
// Results of an accepted byte are registered into the result queue in order.
// Throughput: one byte per cycle; a byte giving two results needs two output
// transactions, and the input stalls when the 4-entry result queue lacks room.
// Reset: synchronous; parser waits for a version byte, the queue is emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diameter_message_avp_parser (
   input  logic     clock,
   input  logic     reset,
   dmap_req_if.sink req_chan,
   dmap_rsp_if.source rsp_chan
);
   import dmap_pkg::*;

   typedef enum logic [3:0] {
      PH_VER, PH_HDR, PH_ACODE, PH_AFLAGS, PH_ALEN,
      PH_AVEND, PH_DATA, PH_PAD, PH_TRAIL, PH_WAIT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] byte_position_ff, byte_position_in;
   logic [23:0] message_length_ff, message_length_in;
   logic [31:0] assembly_shift_ff, assembly_shift_in;
   logic [63:0] header_fields_ff, header_fields_in;
   logic [63:0] header_ids_ff, header_ids_in;
   logic [31:0] avp_code_ff, avp_code_in;
   logic [7:0]  avp_flags_ff, avp_flags_in;
   logic [23:0] avp_remaining_ff, avp_remaining_in;
   logic [1:0]  pad_remaining_ff, pad_remaining_in;

   logic            accept;
   logic            queue_room;
   logic [7:0]      in_byte;
   logic            buf_end;
   logic [23:0]     pos;
   logic [24:0]     pos_plus1;
   logic [24:0]     pos_plus12;
   logic [24:0]     msg_len_ext;
   logic [31:0]     shift_word;
   logic [63:0]     fields_shift;
   logic [23:0]     avp_len;
   logic [23:0]     avp_hdr_len;
   logic [2:0]      code_left;
   logic [1:0]      len_left;
   logic [25:0]     data_limit;

   logic            active;
   logic            err_hit;
   logic            fin_hit;
   logic            clear_state;
   phase_type       clear_phase;
   logic            do_finish;
   logic            do_after;
   logic [23:0]     fin_dl;
   logic [31:0]     fin_vendor;
   logic            prim_valid;
   rsp_payload_type prim;
   logic            second_valid;
   rsp_payload_type second;
   logic [1:0]      push_count;
   rsp_payload_type push_first;
   rsp_payload_type push_second;

   assign in_byte    = req_chan.in_byte;
   assign buf_end    = req_chan.buffer_end;
   assign accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = queue_room;

   assign pos          = byte_position_ff;
   assign pos_plus1    = {1'b0, pos} + 25'd1;
   assign pos_plus12   = {1'b0, pos} + 25'd12;
   assign msg_len_ext  = {1'b0, message_length_ff};
   assign shift_word   = {assembly_shift_ff[23:0], in_byte};
   assign fields_shift = {header_fields_ff[55:0], in_byte};
   assign avp_len      = shift_word[23:0];
   assign avp_hdr_len  = avp_flags_ff[VENDOR_FLAG_BIT] ? AVP_HDR_VENDOR : AVP_HDR_PLAIN;
   assign code_left    = avp_remaining_ff[2:0] - 3'd1;
   assign len_left     = avp_remaining_ff[1:0] - 2'd1;

   // decode one byte against the current parse phase
   always_comb begin
      phase_in          = phase_ff;
      byte_position_in  = byte_position_ff;
      message_length_in = message_length_ff;
      assembly_shift_in = assembly_shift_ff;
      header_fields_in  = header_fields_ff;
      header_ids_in     = header_ids_ff;
      avp_code_in       = avp_code_ff;
      avp_flags_in      = avp_flags_ff;
      avp_remaining_in  = avp_remaining_ff;
      pad_remaining_in  = pad_remaining_ff;

      active       = 1'b1;
      err_hit      = 1'b0;
      fin_hit      = 1'b0;
      clear_state  = 1'b0;
      clear_phase  = PH_VER;
      do_finish    = 1'b0;
      do_after     = 1'b0;
      fin_dl       = avp_remaining_ff;
      fin_vendor   = '0;
      data_limit   = '0;
      prim_valid   = 1'b0;
      prim         = make_rsp(KIND_HEADER, ERR_NONE, '0, '0, '0, '0, '0, '0, '0);
      second_valid = 1'b0;
      second       = make_rsp(KIND_MSG_END, ERR_NONE, '0, '0, '0, '0, '0, '0, '0);

      case (phase_ff)
         PH_VER: begin
            header_fields_in = {56'd0, in_byte};
            byte_position_in = 24'd1;
            if (buf_end) begin
               prim_valid = 1'b1;
               prim = make_rsp(KIND_ERROR, ERR_BUF_UNDER_HDR, '0, '0, '0, '0, '0, '0, '0);
               err_hit = 1'b1;
            end else begin
               phase_in = PH_HDR;
            end
         end
         PH_HDR: begin
            if (pos < 24'd8) begin
               header_fields_in = fields_shift;
            end else if (pos < 24'd16) begin
               header_ids_in = {header_ids_ff[55:0], in_byte};
            end else begin
               assembly_shift_in = shift_word;
            end
            if (pos == 24'd3) begin
               message_length_in = fields_shift[23:0];
            end
            byte_position_in = pos_plus1[23:0];
            if (pos < LAST_HDR_POS) begin
               if (buf_end) begin
                  prim_valid = 1'b1;
                  prim = make_rsp(KIND_ERROR, ERR_BUF_UNDER_HDR,
                                  '0, '0, '0, '0, '0, '0, '0);
                  err_hit = 1'b1;
               end
            end else if (header_fields_ff[63:56] != VERSION_OK) begin
               prim_valid = 1'b1;
               prim = make_rsp(KIND_ERROR, ERR_VERSION, '0, '0, '0, '0, '0, '0, '0);
               err_hit = 1'b1;
            end else begin
               prim_valid = 1'b1;
               prim = make_rsp(KIND_HEADER, ERR_NONE, header_fields_ff[31:24],
                               {8'd0, header_fields_ff[23:0]}, header_ids_ff[63:32],
                               header_ids_ff[31:0], shift_word, message_length_ff, '0);
               if (message_length_ff <= HDR_MSG_LEN) begin
                  fin_hit = 1'b1;
               end else begin
                  phase_in          = PH_ACODE;
                  avp_remaining_in  = 24'd4;
                  assembly_shift_in = '0;
               end
            end
         end
         PH_ACODE: begin
            byte_position_in = pos_plus1[23:0];
            if (avp_remaining_ff >= 24'd4 && pos_plus12 > msg_len_ext) begin
               prim_valid = 1'b1;
               prim = make_rsp(KIND_ERROR, ERR_AVP_HDR_SHORT, '0, '0, '0, '0, '0, '0, '0);
               err_hit = 1'b1;
            end else begin
               assembly_shift_in = shift_word;
               avp_remaining_in  = {21'd0, code_left};
               if (code_left == 3'd0) begin
                  avp_code_in = shift_word;
                  phase_in    = PH_AFLAGS;
               end
            end
         end
         PH_AFLAGS: begin
            byte_position_in  = pos_plus1[23:0];
            avp_flags_in      = in_byte;
            phase_in          = PH_ALEN;
            avp_remaining_in  = 24'd3;
            assembly_shift_in = '0;
         end
         PH_ALEN: begin
            byte_position_in  = pos_plus1[23:0];
            assembly_shift_in = shift_word;
            avp_remaining_in  = {22'd0, len_left};
            if (len_left == 2'd0) begin
               if (avp_len < avp_hdr_len) begin
                  prim_valid = 1'b1;
                  prim = make_rsp(KIND_ERROR, ERR_AVP_LENGTH, '0, '0, '0, '0, '0, '0, '0);
                  err_hit = 1'b1;
               end else begin
                  avp_remaining_in = avp_len - avp_hdr_len;
                  if (avp_flags_ff[VENDOR_FLAG_BIT]) begin
                     phase_in          = PH_AVEND;
                     pad_remaining_in  = 2'd3;
                     assembly_shift_in = '0;
                  end else begin
                     do_finish  = 1'b1;
                     fin_dl     = avp_len - avp_hdr_len;
                     fin_vendor = '0;
                  end
               end
            end
         end
         PH_AVEND: begin
            byte_position_in  = pos_plus1[23:0];
            assembly_shift_in = shift_word;
            if (pad_remaining_ff == 2'd0) begin
               do_finish  = 1'b1;
               fin_dl     = avp_remaining_ff;
               fin_vendor = shift_word;
            end else begin
               pad_remaining_in = pad_remaining_ff - 2'd1;
            end
         end
         PH_DATA: begin
            byte_position_in = pos_plus1[23:0];
            prim_valid = 1'b1;
            prim = make_rsp(KIND_AVP_DATA, ERR_NONE, '0, '0, '0, '0, '0, '0, in_byte);
            avp_remaining_in = avp_remaining_ff - 24'd1;
            if (avp_remaining_in == 24'd0) begin
               do_after = 1'b1;
            end
         end
         PH_PAD: begin
            byte_position_in = pos_plus1[23:0];
            pad_remaining_in = pad_remaining_ff - 2'd1;
            if (pos_plus1 >= msg_len_ext) begin
               fin_hit = 1'b1;
            end else if (pad_remaining_in == 2'd0) begin
               phase_in          = PH_ACODE;
               avp_remaining_in  = 24'd4;
               assembly_shift_in = '0;
            end
         end
         default: begin
            // drop bytes until the buffer ends
            active = 1'b0;
            if (buf_end) begin
               clear_state = 1'b1;
            end
         end
      endcase

      // close an AVP header: check its data fits, then emit it
      if (do_finish) begin
         data_limit = {2'b0, pos} + 26'd1 + {2'b0, fin_dl};
         if (data_limit > {2'b0, message_length_ff}) begin
            prim_valid = 1'b1;
            prim = make_rsp(KIND_ERROR, ERR_DATA_SHORT, '0, '0, '0, '0, '0, '0, '0);
            err_hit = 1'b1;
         end else begin
            prim_valid = 1'b1;
            prim = make_rsp(KIND_AVP_HEADER, ERR_NONE, avp_flags_ff, avp_code_ff,
                            fin_vendor, '0, '0, fin_dl, '0);
            pad_remaining_in = 2'd0 - fin_dl[1:0];
            if (fin_dl != 24'd0) begin
               phase_in = PH_DATA;
            end else begin
               do_after = 1'b1;
            end
         end
      end

      // after the data of an AVP: end message, skip padding or start next AVP
      if (do_after) begin
         if (pos_plus1 >= msg_len_ext) begin
            fin_hit = 1'b1;
         end else if (pad_remaining_in != 2'd0) begin
            phase_in = PH_PAD;
         end else begin
            phase_in          = PH_ACODE;
            avp_remaining_in  = 24'd4;
            assembly_shift_in = '0;
         end
      end

      if (fin_hit) begin
         second_valid = 1'b1;
      end

      // settle the message on error, message end or buffer end
      if (active) begin
         if (err_hit) begin
            clear_state = 1'b1;
            clear_phase = buf_end ? PH_VER : PH_WAIT;
         end else if (fin_hit) begin
            clear_state = 1'b1;
            clear_phase = buf_end ? PH_VER : PH_TRAIL;
         end else if (buf_end) begin
            second_valid = 1'b1;
            second = make_rsp(KIND_ERROR, ERR_MSG_LONG, '0, '0, '0, '0, '0, '0, '0);
            clear_state = 1'b1;
         end
      end

      if (clear_state) begin
         phase_in          = clear_phase;
         byte_position_in  = '0;
         message_length_in = '0;
         assembly_shift_in = '0;
         header_fields_in  = '0;
         header_ids_in     = '0;
         avp_code_in       = '0;
         avp_flags_in      = '0;
         avp_remaining_in  = '0;
         pad_remaining_in  = '0;
      end
   end

   // order the results of this byte and mark the last one
   always_comb begin
      push_count = '0;
      if (accept) begin
         push_count = {1'b0, prim_valid} + {1'b0, second_valid};
      end
      push_first  = prim_valid ? prim : second;
      push_second = second;
      push_first.last_of_run  = !(prim_valid && second_valid);
      push_second.last_of_run = 1'b1;
   end

   // hold parse state, advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_VER;
         byte_position_ff  <= '0;
         message_length_ff <= '0;
         assembly_shift_ff <= '0;
         header_fields_ff  <= '0;
         header_ids_ff     <= '0;
         avp_code_ff       <= '0;
         avp_flags_ff      <= '0;
         avp_remaining_ff  <= '0;
         pad_remaining_ff  <= '0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         byte_position_ff  <= byte_position_in;
         message_length_ff <= message_length_in;
         assembly_shift_ff <= assembly_shift_in;
         header_fields_ff  <= header_fields_in;
         header_ids_ff     <= header_ids_in;
         avp_code_ff       <= avp_code_in;
         avp_flags_ff      <= avp_flags_in;
         avp_remaining_ff  <= avp_remaining_in;
         pad_remaining_ff  <= pad_remaining_in;
      end
   end

   dmap_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second),
      .push_room   (queue_room),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== design/dmap_out_queue.sv =====
// ----------------------------------------------------------------------------
// Diameter parser output queue
// Four-entry result queue; takes up to two results per cycle from the parser
// and presents them one per transaction on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmap_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                push_count,
   input  dmap_pkg::rsp_payload_type push_first,
   input  dmap_pkg::rsp_payload_type push_second,
   output logic                      push_room,
   dmap_rsp_if.source                rsp_chan
);
   import dmap_pkg::*;

   rsp_payload_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;
   rsp_payload_type    head;

   // take a transaction off the head
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign push_room = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write one or two entries in order
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push_second;
      end
   end

   // present the head entry
   assign head                 = entry_ff[rd_ptr_ff];
   assign rsp_chan.valid       = count_ff != '0;
   assign rsp_chan.kind        = head.kind;
   assign rsp_chan.err_code    = head.err_code;
   assign rsp_chan.flags_out   = head.flags_out;
   assign rsp_chan.code_out    = head.code_out;
   assign rsp_chan.ident_out   = head.ident_out;
   assign rsp_chan.hop_out     = head.hop_out;
   assign rsp_chan.end_out     = head.end_out;
   assign rsp_chan.length_out  = head.length_out;
   assign rsp_chan.data_out    = head.data_out;
   assign rsp_chan.last_of_run = head.last_of_run;

endmodule

// ===== design/dmap_checker.sv =====
// ----------------------------------------------------------------------------
// Diameter parser port checker
// Concurrent checks on the result channel as seen at the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmap_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [2:0]  rsp_err_code,
   input logic [7:0]  rsp_data_out,
   input logic        rsp_last
);
   import dmap_pkg::*;

   // queue comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // stalled transaction stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // stalled transaction keeps its kind, error code, data and last flag
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_err_code)
                                   && $stable(rsp_data_out) && $stable(rsp_last))
      else $error("result changed while stalled");

   // an error code appears exactly on error results
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_err_code != ERR_NONE)))
      else $error("error code and result kind disagree");

   // errors and message ends close the run of a byte
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR || rsp_kind == KIND_MSG_END) |-> rsp_last)
      else $error("error or message end not last of its byte");

endmodule

bind diameter_message_avp_parser dmap_checker u_dmap_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_err_code (rsp_chan.err_code),
   .rsp_data_out (rsp_chan.data_out),
   .rsp_last     (rsp_chan.last_of_run)
);

// ===== tb/sv/diameter_message_avp_parser_tb.sv =====
// ----------------------------------------------------------------------------
// Diameter message and AVP parser testbench
// Feeds whole message buffers byte by byte, good ones with random content
// mixed with broken ones, and tracks the parser with a cycle-free model of
// its state. Every result record is checked in order against that model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diameter_message_avp_parser_tb;
   import dmap_pkg::*;

   localparam int          ITEM_TARGET  = 2000;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          SETTLE_TICKS = 16;
   localparam int          MAX_REPORTS  = 10;

   typedef enum logic [3:0] {
      PS_VERSION, PS_HEADER, PS_AVP_CODE, PS_AVP_FLAGS, PS_AVP_LENGTH,
      PS_VENDOR, PS_DATA, PS_PAD, PS_TRAILER, PS_DRAIN
   } parse_phase_type;

   typedef enum int {
      SHAPE_GOOD, SHAPE_BAD_VERSION, SHAPE_SHORT_BUFFER, SHAPE_TRUNCATED,
      SHAPE_AVP_LEN_LOW, SHAPE_DATA_OVERRUN, SHAPE_TAIL_SHORT, SHAPE_SMALL_LENGTH,
      SHAPE_NOISE
   } msg_shape_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } buffer_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dmap_req_if req_chan ();
   dmap_rsp_if rsp_chan ();

   diameter_message_avp_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   buffer_byte_type buffer_bytes[$];
   rsp_payload_type parse_results_due[$];
   int              total_items;
   int              bytes_accepted = 0;
   int              results_seen = 0;
   int              mismatch_count = 0;
   int unsigned     cycle_count = 0;

   // parser model state
   parse_phase_type ps_phase;
   logic [23:0]     ps_pos;
   logic [23:0]     ps_msg_len;
   logic [31:0]     ps_shift;
   logic [63:0]     ps_hdr_fields;
   logic [63:0]     ps_hdr_ids;
   logic [31:0]     ps_avp_code;
   logic [7:0]      ps_avp_flags;
   logic [23:0]     ps_avp_left;
   logic [1:0]      ps_pad_left;

   // results of the byte being parsed
   rsp_payload_type step_buf[2];
   int              step_count;
   logic            step_err;
   logic            step_done;

   function automatic logic [7:0] rand_octet();
      return 8'($urandom_range(255, 0));
   endfunction

   function automatic string record_text(input rsp_payload_type r);
      return {$sformatf("kind=%0d err=%0d flags=%h code=%h ident=%h ",
                        r.kind, r.err_code, r.flags_out, r.code_out, r.ident_out),
              $sformatf("hop=%h end=%h len=%h data=%h last=%b",
                        r.hop_out, r.end_out, r.length_out, r.data_out, r.last_of_run)};
   endfunction

   task automatic clear_parser();
      ps_phase      = PS_VERSION;
      ps_pos        = '0;
      ps_msg_len    = '0;
      ps_shift      = '0;
      ps_hdr_fields = '0;
      ps_hdr_ids    = '0;
      ps_avp_code   = '0;
      ps_avp_flags  = '0;
      ps_avp_left   = '0;
      ps_pad_left   = '0;
   endtask

   // Record one result of the current byte; a byte never gives more than two.
   task automatic add_result(input logic [2:0] kind, input logic [2:0] err,
                             input logic [7:0] flags, input logic [31:0] code,
                             input logic [31:0] ident, input logic [31:0] hop,
                             input logic [31:0] e2e, input logic [23:0] len,
                             input logic [7:0] data);
      rsp_payload_type r;
      r.kind        = kind;
      r.err_code    = err;
      r.flags_out   = flags;
      r.code_out    = code;
      r.ident_out   = ident;
      r.hop_out     = hop;
      r.end_out     = e2e;
      r.length_out  = len;
      r.data_out    = data;
      r.last_of_run = 1'b0;
      if (step_count < 2) begin
         step_buf[step_count] = r;
         step_count++;
      end
   endtask

   task automatic flag_error(input logic [2:0] err);
      add_result(KIND_ERROR, err, '0, '0, '0, '0, '0, '0, '0);
      step_err = 1'b1;
   endtask

   task automatic close_message();
      add_result(KIND_MSG_END, ERR_NONE, '0, '0, '0, '0, '0, '0, '0);
      step_done = 1'b1;
   endtask

   task automatic start_avp();
      ps_phase    = PS_AVP_CODE;
      ps_avp_left = 24'd4;
      ps_shift    = '0;
   endtask

   // After the last data byte: end the message, skip padding or start the next AVP.
   task automatic after_avp_data(input logic [31:0] p);
      if (p + 1 >= ps_msg_len) begin
         close_message();
      end else if (ps_pad_left != 0) begin
         ps_phase = PS_PAD;
      end else begin
         start_avp();
      end
   endtask

   task automatic finish_avp_header(input logic [31:0] p, input logic [31:0] vendor_id);
      if (p + 1 + ps_avp_left > ps_msg_len) begin
         flag_error(ERR_DATA_SHORT);
      end else begin
         add_result(KIND_AVP_HEADER, ERR_NONE, ps_avp_flags, ps_avp_code, vendor_id,
                    '0, '0, ps_avp_left, '0);
         ps_pad_left = 2'd0 - ps_avp_left[1:0];
         if (ps_avp_left != 0) ps_phase = PS_DATA;
         else after_avp_data(p);
      end
   endtask

   // Advance the parser model by one accepted byte and queue its results.
   task automatic parse_byte(input logic [7:0] octet, input logic last_octet);
      logic [31:0] p;
      logic        active;
      logic [23:0] field_len;
      logic [23:0] hdr_len;
      p          = {8'd0, ps_pos};
      active     = 1'b1;
      step_count = 0;
      step_err   = 1'b0;
      step_done  = 1'b0;
      case (ps_phase)
         PS_VERSION: begin
            ps_hdr_fields = {56'd0, octet};
            ps_pos        = 24'd1;
            if (last_octet) flag_error(ERR_BUF_UNDER_HDR);
            else ps_phase = PS_HEADER;
         end
         PS_HEADER: begin
            if (p < 8) ps_hdr_fields = {ps_hdr_fields[55:0], octet};
            else if (p < 16) ps_hdr_ids = {ps_hdr_ids[55:0], octet};
            else ps_shift = {ps_shift[23:0], octet};
            if (p == 3) ps_msg_len = ps_hdr_fields[23:0];
            ps_pos = p[23:0] + 24'd1;
            if (p < LAST_HDR_POS) begin
               if (last_octet) flag_error(ERR_BUF_UNDER_HDR);
            end else if (ps_hdr_fields[63:56] != VERSION_OK) begin
               flag_error(ERR_VERSION);
            end else begin
               add_result(KIND_HEADER, ERR_NONE, ps_hdr_fields[31:24],
                          {8'd0, ps_hdr_fields[23:0]}, ps_hdr_ids[63:32],
                          ps_hdr_ids[31:0], ps_shift, ps_msg_len, '0);
               if (ps_msg_len <= HDR_MSG_LEN) close_message();
               else start_avp();
            end
         end
         PS_AVP_CODE: begin
            ps_pos = p[23:0] + 24'd1;
            if (ps_avp_left >= 4 && p + 12 > ps_msg_len) begin
               flag_error(ERR_AVP_HDR_SHORT);
            end else begin
               ps_shift    = {ps_shift[23:0], octet};
               ps_avp_left = ps_avp_left - 24'd1;
               if (ps_avp_left == 0) begin
                  ps_avp_code = ps_shift;
                  ps_phase    = PS_AVP_FLAGS;
               end
            end
         end
         PS_AVP_FLAGS: begin
            ps_pos       = p[23:0] + 24'd1;
            ps_avp_flags = octet;
            ps_phase     = PS_AVP_LENGTH;
            ps_avp_left  = 24'd3;
            ps_shift     = '0;
         end
         PS_AVP_LENGTH: begin
            ps_pos      = p[23:0] + 24'd1;
            ps_shift    = {ps_shift[23:0], octet};
            ps_avp_left = ps_avp_left - 24'd1;
            if (ps_avp_left == 0) begin
               field_len = ps_shift[23:0];
               hdr_len   = ps_avp_flags[VENDOR_FLAG_BIT] ? AVP_HDR_VENDOR : AVP_HDR_PLAIN;
               if (field_len < hdr_len) begin
                  flag_error(ERR_AVP_LENGTH);
               end else begin
                  ps_avp_left = field_len - hdr_len;
                  if (ps_avp_flags[VENDOR_FLAG_BIT]) begin
                     ps_phase    = PS_VENDOR;
                     ps_pad_left = 2'd3;
                     ps_shift    = '0;
                  end else begin
                     finish_avp_header(p, '0);
                  end
               end
            end
         end
         PS_VENDOR: begin
            ps_pos   = p[23:0] + 24'd1;
            ps_shift = {ps_shift[23:0], octet};
            if (ps_pad_left == 0) finish_avp_header(p, ps_shift);
            else ps_pad_left = ps_pad_left - 2'd1;
         end
         PS_DATA: begin
            ps_pos = p[23:0] + 24'd1;
            add_result(KIND_AVP_DATA, ERR_NONE, '0, '0, '0, '0, '0, '0, octet);
            ps_avp_left = ps_avp_left - 24'd1;
            if (ps_avp_left == 0) after_avp_data(p);
         end
         PS_PAD: begin
            ps_pos      = p[23:0] + 24'd1;
            ps_pad_left = ps_pad_left - 2'd1;
            if (p + 1 >= ps_msg_len) close_message();
            else if (ps_pad_left == 0) start_avp();
         end
         default: begin
            // drop bytes until the buffer ends
            active = 1'b0;
            if (last_octet) clear_parser();
         end
      endcase

      if (active) begin
         if (step_err) begin
            clear_parser();
            if (!last_octet) ps_phase = PS_DRAIN;
         end else if (step_done) begin
            clear_parser();
            if (!last_octet) ps_phase = PS_TRAILER;
         end else if (last_octet) begin
            flag_error(ERR_MSG_LONG);
            clear_parser();
         end
      end

      if (step_count != 0) step_buf[step_count - 1].last_of_run = 1'b1;
      for (int i = 0; i < step_count; i++) parse_results_due.push_back(step_buf[i]);
   endtask

   // Queue one buffer, flagging its final byte.
   task automatic push_buffer(input logic [7:0] octets[$]);
      buffer_byte_type item;
      foreach (octets[i]) begin
         item.data = octets[i];
         item.last = (i == octets.size() - 1);
         buffer_bytes.push_back(item);
      end
   endtask

   // Build one message buffer of the given shape with random content.
   task automatic add_message(input msg_shape_type shape);
      logic [7:0]  body[$];
      logic [7:0]  octets[$];
      logic [7:0]  avp_flag_byte;
      logic [7:0]  ver;
      logic [23:0] len_field;
      logic        patch_len;
      int          avp_total;
      int          data_len;
      int          hdr_len;
      int          pad_len;
      int          len_at;
      int          msg_len;
      int          cut;
      if (shape == SHAPE_NOISE) begin
         repeat ($urandom_range(40, 1)) octets.push_back(rand_octet());
         if ($urandom_range(1, 0) != 0) octets[0] = VERSION_OK;
         push_buffer(octets);
         return;
      end

      if (shape == SHAPE_SMALL_LENGTH) avp_total = 0;
      else if (shape == SHAPE_GOOD) avp_total = $urandom_range(4, 0);
      else avp_total = $urandom_range(4, 1);
      len_at  = 0;
      hdr_len = int'(AVP_HDR_PLAIN);
      data_len = 0;
      pad_len = 0;

      // lay out the AVPs; vendor id, data and padding are random bytes
      repeat (avp_total) begin
         avp_flag_byte = rand_octet();
         hdr_len  = avp_flag_byte[VENDOR_FLAG_BIT] ? int'(AVP_HDR_VENDOR) : int'(AVP_HDR_PLAIN);
         data_len = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 0);
         pad_len  = (4 - data_len % 4) % 4;
         len_field = 24'(hdr_len + data_len);
         repeat (4) body.push_back(rand_octet());
         body.push_back(avp_flag_byte);
         len_at = body.size();
         body.push_back(len_field[23:16]);
         body.push_back(len_field[15:8]);
         body.push_back(len_field[7:0]);
         repeat (hdr_len + data_len + pad_len - 8) body.push_back(rand_octet());
      end

      // break the message as the shape asks
      msg_len   = int'(HDR_MSG_LEN) + body.size();
      patch_len = 1'b0;
      case (shape)
         SHAPE_AVP_LEN_LOW: begin
            len_field = 24'($urandom_range(hdr_len - 1, 0));
            patch_len = 1'b1;
         end
         SHAPE_DATA_OVERRUN: begin
            if ($urandom_range(1, 0) != 0) begin
               len_field = 24'($urandom_range(24'hFFFFFF, hdr_len + data_len + 1));
               patch_len = 1'b1;
            end else begin
               msg_len = msg_len - $urandom_range(4, 1);
            end
         end
         SHAPE_TAIL_SHORT: begin
            repeat ($urandom_range(11, 1)) body.push_back(rand_octet());
            msg_len = int'(HDR_MSG_LEN) + body.size();
         end
         SHAPE_SMALL_LENGTH: msg_len = $urandom_range(HDR_MSG_LEN, 0);
         SHAPE_GOOD: begin
            // let the last padding fall past the message length
            if (avp_total != 0 && pad_len != 0 && $urandom_range(3, 0) == 0)
               msg_len = msg_len - pad_len;
         end
         default: ;
      endcase
      if (patch_len) begin
         body[len_at]     = len_field[23:16];
         body[len_at + 1] = len_field[15:8];
         body[len_at + 2] = len_field[7:0];
      end

      // message header: version, length, flags, command, application, hop, end-to-end
      ver = VERSION_OK;
      if (shape == SHAPE_BAD_VERSION) begin
         ver = 8'($urandom_range(254, 0));
         if (ver >= VERSION_OK) ver = ver + 8'd1;
      end
      len_field = 24'(msg_len);
      octets.push_back(ver);
      octets.push_back(len_field[23:16]);
      octets.push_back(len_field[15:8]);
      octets.push_back(len_field[7:0]);
      repeat (16) octets.push_back(rand_octet());
      foreach (body[i]) octets.push_back(body[i]);

      // cut the buffer short or add trailing bytes
      if (shape == SHAPE_TRUNCATED) cut = $urandom_range(octets.size() - 1, HDR_MSG_LEN);
      else if (shape == SHAPE_SHORT_BUFFER) cut = $urandom_range(LAST_HDR_POS, 1);
      else cut = octets.size();
      while (octets.size() > cut) octets.delete(octets.size() - 1);
      if ((shape == SHAPE_GOOD || shape == SHAPE_SMALL_LENGTH) && $urandom_range(3, 0) == 0)
         repeat ($urandom_range(6, 1)) octets.push_back(rand_octet());
      push_buffer(octets);
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.in_byte    <= 8'd0;
         req_chan.buffer_end <= 1'b0;
         burst_left          <= $urandom_range(40, 1);
         gap_left            <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0) begin
            req_chan.valid <= 1'b0;
            gap_left       <= gap_left - 1;
         end else if (buffer_bytes.size() != 0) begin
            req_chan.valid      <= 1'b1;
            req_chan.in_byte    <= buffer_bytes[0].data;
            req_chan.buffer_end <= buffer_bytes[0].last;
            buffer_bytes.delete(0);
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: a random 16-bit ready mask, stepped through bit by bit and redrawn each time the step counter wraps.
   logic [15:0] ready_mask;
   logic [5:0]  ready_step;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_mask     <= 16'hFFFF;
         ready_step     <= 6'd0;
      end else begin
         if (ready_step == 6'd0) begin
            case ($urandom_range(3, 0))
               0: ready_mask <= 16'hFFFF;
               1: ready_mask <= 16'($urandom) | 16'h0001;
               2: ready_mask <= (16'($urandom) & 16'($urandom)) | 16'h0001;
               default: ready_mask <= 16'($urandom) | 16'($urandom);
            endcase
         end
         rsp_chan.ready <= ready_mask[ready_step[3:0]];
         ready_step     <= ready_step + 6'd1;
      end
   end

   // Monitor: predict on each byte transaction, check each result transaction.
   always @(posedge clock) begin
      rsp_payload_type seen;
      rsp_payload_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            parse_byte(req_chan.in_byte, req_chan.buffer_end);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.kind        = rsp_chan.kind;
            seen.err_code    = rsp_chan.err_code;
            seen.flags_out   = rsp_chan.flags_out;
            seen.code_out    = rsp_chan.code_out;
            seen.ident_out   = rsp_chan.ident_out;
            seen.hop_out     = rsp_chan.hop_out;
            seen.end_out     = rsp_chan.end_out;
            seen.length_out  = rsp_chan.length_out;
            seen.data_out    = rsp_chan.data_out;
            seen.last_of_run = rsp_chan.last_of_run;
            if (parse_results_due.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("result %0d unexpected: %s", results_seen, record_text(seen));
               mismatch_count++;
            end else begin
               want = parse_results_due.pop_front();
               if (seen !== want) begin
                  if (mismatch_count < MAX_REPORTS) begin
                     $display("result %0d mismatch", results_seen);
                     $display("  expected %s", record_text(want));
                     $display("  actual   %s", record_text(seen));
                  end
                  mismatch_count++;
               end
            end
            results_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [7:0]    octets[$];
      msg_shape_type shape;
      int            pick;
      req_chan.valid      = 1'b0;
      req_chan.in_byte    = 8'd0;
      req_chan.buffer_end = 1'b0;
      rsp_chan.ready      = 1'b0;
      clear_parser();

      // one-byte buffer: error on the version byte
      octets = '{8'hFF};
      push_buffer(octets);
      // header only, length zero, all other fields set
      octets = '{VERSION_OK, 8'h00, 8'h00, 8'h00};
      repeat (16) octets.push_back(8'hFF);
      push_buffer(octets);
      // short buffer of zeros
      octets = '{8'h00, 8'h00, 8'h00};
      push_buffer(octets);

      // random messages, mostly well formed
      while (buffer_bytes.size() < ITEM_TARGET) begin
         pick = $urandom_range(99, 0);
         if (pick < 50) shape = SHAPE_GOOD;
         else if (pick < 56) shape = SHAPE_BAD_VERSION;
         else if (pick < 62) shape = SHAPE_SHORT_BUFFER;
         else if (pick < 70) shape = SHAPE_TRUNCATED;
         else if (pick < 77) shape = SHAPE_AVP_LEN_LOW;
         else if (pick < 84) shape = SHAPE_DATA_OVERRUN;
         else if (pick < 90) shape = SHAPE_TAIL_SHORT;
         else if (pick < 95) shape = SHAPE_SMALL_LENGTH;
         else shape = SHAPE_NOISE;
         add_message(shape);
      end
      total_items = buffer_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted != total_items) @(posedge clock);
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dmap_pkg.sv
design/dmap_req_if.sv
design/dmap_rsp_if.sv
design/dmap_out_queue.sv
design/diameter_message_avp_parser.sv
design/dmap_checker.sv
tb/sv/diameter_message_avp_parser_tb.sv
